[rtl/tcbb_pkg.sv]
// shared constants and control types for the two-column bucket binner
package tcbb_pkg;

  localparam int INDEX_BITS_DEF   = 6;
  localparam int ROW_BITS_DEF     = 20;
  localparam int VALUE_BITS       = 32;
  localparam int READ_BUCKET_BITS = 12;
  localparam int ACTION_BITS      = 2;

  localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_READ   = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic take;       // latch item fields and read its bucket
    logic sel_read;   // address the read bucket rather than the binned one
    logic clr_wr;     // write reset value at sweep address
    logic upd_wr;     // write back updated bucket
    logic out_load;   // move read data into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last; // sweep address at last bucket
    logic out_free;   // output register can take a new item
  } sts_t;

endpackage

[rtl/tcbb_ctrl.sv]
// controller state machine for the two-column bucket binner
module tcbb_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [tcbb_pkg::ACTION_BITS-1:0]  action,
  output logic                              in_ready,
  output tcbb_pkg::cmd_t                    cmd,
  input  tcbb_pkg::sts_t                    sts
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       is_read;
  logic       is_read_next;

  always_comb begin
    state_next   = state;
    is_read_next = is_read;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.sel_read = (action == tcbb_pkg::ACT_READ);
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (action)
            tcbb_pkg::ACT_INSERT: begin
              cmd.take     = 1'b1;
              is_read_next = 1'b0;
              state_next   = S_EXEC;
            end
            tcbb_pkg::ACT_READ: begin
              cmd.take     = 1'b1;
              is_read_next = 1'b1;
              state_next   = S_EXEC;
            end
            tcbb_pkg::ACT_CLEAR: begin
              state_next = S_CLEAR;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_EXEC: begin
        if (!is_read) begin
          cmd.upd_wr = 1'b1;
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      is_read <= 1'b0;
    end else begin
      state   <= state_next;
      is_read <= is_read_next;
    end
  end

endmodule

[rtl/tcbb_dp.sv]
// datapath: bucket memory, clearing sweep, update logic and output register
module tcbb_dp #(
  parameter int INDEX_BITS = tcbb_pkg::INDEX_BITS_DEF,
  parameter int ROW_BITS   = tcbb_pkg::ROW_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tcbb_pkg::cmd_t                        cmd,
  output tcbb_pkg::sts_t                        sts,
  input  logic [ROW_BITS-1:0]                   row_index,
  input  logic [tcbb_pkg::VALUE_BITS-1:0]       value_a,
  input  logic [tcbb_pkg::VALUE_BITS-1:0]       value_b,
  input  logic                                  is_selected,
  input  logic [tcbb_pkg::READ_BUCKET_BITS-1:0] read_bucket,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  bucket_used,
  output logic [ROW_BITS:0]                     row_count,
  output logic [ROW_BITS-1:0]                   least_row,
  output logic [ROW_BITS-1:0]                   least_selected_row
);

  localparam int BKT_BITS = 2 * INDEX_BITS;
  localparam int DEPTH    = 1 << BKT_BITS;
  localparam int CNT_BITS = ROW_BITS + 1;
  localparam int ENT_BITS = CNT_BITS + 2 * ROW_BITS;
  localparam logic [ENT_BITS-1:0] CLR_ENT =
    {{(2 * ROW_BITS){1'b1}}, {CNT_BITS{1'b0}}};

  // entry layout from the low bit up: count, least row, least selected row
  logic [ENT_BITS-1:0] mem [DEPTH];
  logic [ENT_BITS-1:0] rd_data;

  logic [BKT_BITS-1:0] sweep_addr;
  logic [BKT_BITS-1:0] bkt;
  logic [BKT_BITS-1:0] bin_bkt;
  logic [BKT_BITS-1:0] rd_addr;
  logic [31:0]         rb_ext;
  logic [ROW_BITS-1:0] row;
  logic                sel;

  logic [CNT_BITS-1:0] cnt;
  logic [CNT_BITS-1:0] cnt_upd;
  logic [ROW_BITS-1:0] least;
  logic [ROW_BITS-1:0] least_upd;
  logic [ROW_BITS-1:0] lsel;
  logic [ROW_BITS-1:0] lsel_upd;

  logic [BKT_BITS-1:0] wr_addr;
  logic [ENT_BITS-1:0] wr_data;
  logic                wr_en;

  assign bin_bkt = {value_b[tcbb_pkg::VALUE_BITS-1 -: INDEX_BITS],
                    value_a[tcbb_pkg::VALUE_BITS-1 -: INDEX_BITS]};
  assign rb_ext  = 32'(read_bucket);
  assign rd_addr = cmd.sel_read ? rb_ext[BKT_BITS-1:0] : bin_bkt;

  assign cnt   = rd_data[CNT_BITS-1:0];
  assign least = rd_data[CNT_BITS +: ROW_BITS];
  assign lsel  = rd_data[CNT_BITS + ROW_BITS +: ROW_BITS];

  // count saturates at 2^ROW_BITS, i.e. once its top bit is set
  assign cnt_upd   = cnt[ROW_BITS] ? cnt : cnt + CNT_BITS'(1);
  assign least_upd = (row < least) ? row : least;
  assign lsel_upd  = (sel && (row < lsel)) ? row : lsel;

  always_comb begin
    wr_en   = cmd.clr_wr | cmd.upd_wr;
    wr_addr = cmd.clr_wr ? sweep_addr : bkt;
    wr_data = cmd.clr_wr ? CLR_ENT : {lsel_upd, least_upd, cnt_upd};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.take) begin
      rd_data <= mem[rd_addr];
      bkt     <= rd_addr;
      row     <= row_index;
      sel     <= is_selected;
    end
  end

  // sweep address wraps to zero after the last bucket
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.clr_wr) begin
      sweep_addr <= sweep_addr + BKT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bucket_used        <= (cnt != '0);
      row_count          <= cnt;
      least_row          <= least;
      least_selected_row <= lsel;
    end
  end

  assign sts.sweep_last = &sweep_addr;
  assign sts.out_free   = !out_valid || out_ready;

endmodule

[rtl/two_column_bucket_binner_core.sv]
// top level of the two-column bucket binner: stream ports, controller and datapath
// insert: the bucket is read when the item is taken and written back in the execute state;
//   a read result enters the output register in the execute state, which waits while the
//   previous result is unclaimed; the next item is taken only after the execute state
// reset and clear: a sweep writes every bucket, 2^(2*INDEX_BITS) of them (4096 by
//   default), with s_tready low; synchronous active-high rst restarts the sweep
module two_column_bucket_binner_core #(
  parameter int INDEX_BITS = tcbb_pkg::INDEX_BITS_DEF,
  parameter int ROW_BITS   = tcbb_pkg::ROW_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // row_index, value_a, value_b, is_selected, read_bucket, zero fill
  input  logic [((ROW_BITS + 77 + 7) / 8) * 8 - 1:0] s_tdata,
  // action
  input  logic [tcbb_pkg::ACTION_BITS-1:0]     s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // bucket_used, row_count, least_row, least_selected_row, zero fill
  output logic [((3 * ROW_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int OUT_USED  = 3 * ROW_BITS + 2;
  localparam int OUT_BITS  = ((OUT_USED + 7) / 8) * 8;
  localparam int VB        = tcbb_pkg::VALUE_BITS;
  localparam int RBB       = tcbb_pkg::READ_BUCKET_BITS;
  // field offsets inside s_tdata
  localparam int OFS_A     = ROW_BITS;
  localparam int OFS_B     = OFS_A + VB;
  localparam int OFS_SEL   = OFS_B + VB;
  localparam int OFS_RB    = OFS_SEL + 1;

  tcbb_pkg::cmd_t cmd;
  tcbb_pkg::sts_t sts;

  logic                bucket_used;
  logic [ROW_BITS:0]   row_count;
  logic [ROW_BITS-1:0] least_row;
  logic [ROW_BITS-1:0] least_selected_row;
  logic [OUT_USED-1:0] out_packed;

  // sequencing: sweep, idle, then the execute state for each insert or read item
  tcbb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .action   (s_tuser),
    .in_ready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // bucket store plus read-modify-write and the output register
  tcbb_dp #(
    .INDEX_BITS (INDEX_BITS),
    .ROW_BITS   (ROW_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .row_index          (s_tdata[ROW_BITS-1:0]),
    .value_a            (s_tdata[OFS_A +: VB]),
    .value_b            (s_tdata[OFS_B +: VB]),
    .is_selected        (s_tdata[OFS_SEL]),
    .read_bucket        (s_tdata[OFS_RB +: RBB]),
    .out_ready          (m_tready),
    .out_valid          (m_tvalid),
    .bucket_used        (bucket_used),
    .row_count          (row_count),
    .least_row          (least_row),
    .least_selected_row (least_selected_row)
  );

  // pack the result, first field lowest, then pad to whole bytes
  assign out_packed = {least_selected_row, least_row, row_count, bucket_used};
  assign m_tdata    = OUT_BITS'(out_packed);

endmodule
